FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the allocator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This check is disabled while reset is held.
`define PHA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// This check is evaluated at every edge, reset included.
`define PHA_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/pha_pkg.sv
// ----------------------------------------------------------------------------
// pha_pkg
// Types, codes and defaults shared by the paged heap allocator modules.
// ----------------------------------------------------------------------------
package pha_pkg;

  localparam int LOGICAL_WORDS_DEF  = 65536;
  localparam int PHYSICAL_WORDS_DEF = 16384;
  localparam int PAGE_WORDS_DEF     = 256;
  localparam int DATA_WIDTH_DEF     = 32;

  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 17;
  localparam int VALUE_W  = 32;
  localparam int FIT_W    = 2;

  localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_WRITE,
    CMD_READ
  } command_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_HOLE,
    ST_NO_FRAME,
    ST_BAD
  } status_t;

  typedef struct packed {
    command_t                   command;
    logic [ADDR_W-1:0]          req_address;
    logic [SIZE_W-1:0]          alloc_size;
    logic signed [VALUE_W-1:0]  write_value;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic [ADDR_W-1:0]          result_address;
    logic signed [VALUE_W-1:0]  read_data;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CH,
    S_SCAN_END,
    S_ALLOC_CHK,
    S_COUNT,
    S_FRAME_CHK,
    S_MARK_RD,
    S_MARK_WR,
    S_MAP,
    S_PCHK_RD,
    S_PCHK_ACC,
    S_XLATE,
    S_DATA_RD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    clear_step;
    logic    scan_init;
    logic    scan_chunk;
    logic    scan_next_word;
    logic    scan_final;
    logic    span_init;
    logic    count_step;
    logic    mark_init;
    logic    mark_write;
    logic    word_next;
    logic    map_step;
    logic    pchk_init;
    logic    pchk_acc;
    logic    data_write;
    logic    res_set;
    status_t res_code;
    logic    load_out;
  } ctl_cmd_t;

  typedef struct packed {
    command_t command;
    logic     size_zero;
    logic     free_bad;
    logic     xlate_bad;
    logic     first_hit;
    logic     found;
    logic     chunk_last;
    logic     word_last;
    logic     span_word_last;
    logic     page_last;
    logic     sub_last;
    logic     frames_short;
  } ctl_sts_t;

endpackage

FILE: design/pha_ram.sv
// ----------------------------------------------------------------------------
// pha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pha_ctrl.sv
// ----------------------------------------------------------------------------
// pha_ctrl
// Sequencer for the allocator: steps the datapath through each request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  pha_pkg::ctl_sts_t   sts,
  output pha_pkg::ctl_cmd_t   cmd
);

  pha_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pha_pkg::S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pha_pkg::S_CLEAR: begin
        if (sts.word_last) state_next = pha_pkg::S_IDLE;
      end
      pha_pkg::S_IDLE: begin
        if (req_valid) state_next = pha_pkg::S_DECODE;
      end
      pha_pkg::S_DECODE: begin
        unique case (sts.command)
          pha_pkg::CMD_ALLOC: state_next = sts.size_zero ? pha_pkg::S_DONE : pha_pkg::S_SCAN_RD;
          pha_pkg::CMD_FREE:  state_next = sts.free_bad ? pha_pkg::S_DONE : pha_pkg::S_MARK_RD;
          default:            state_next = sts.xlate_bad ? pha_pkg::S_DONE : pha_pkg::S_XLATE;
        endcase
      end
      pha_pkg::S_SCAN_RD: state_next = pha_pkg::S_SCAN_CH;
      pha_pkg::S_SCAN_CH: begin
        if (sts.first_hit) begin
          state_next = pha_pkg::S_ALLOC_CHK;
        end else if (sts.chunk_last) begin
          state_next = sts.word_last ? pha_pkg::S_SCAN_END : pha_pkg::S_SCAN_RD;
        end
      end
      pha_pkg::S_SCAN_END: state_next = pha_pkg::S_ALLOC_CHK;
      pha_pkg::S_ALLOC_CHK: state_next = sts.found ? pha_pkg::S_COUNT : pha_pkg::S_DONE;
      pha_pkg::S_COUNT: begin
        if (sts.page_last) state_next = pha_pkg::S_FRAME_CHK;
      end
      pha_pkg::S_FRAME_CHK: state_next = sts.frames_short ? pha_pkg::S_DONE : pha_pkg::S_MARK_RD;
      pha_pkg::S_MARK_RD: state_next = pha_pkg::S_MARK_WR;
      pha_pkg::S_MARK_WR: begin
        if (!sts.span_word_last) begin
          state_next = pha_pkg::S_MARK_RD;
        end else if (sts.command == pha_pkg::CMD_ALLOC) begin
          state_next = pha_pkg::S_MAP;
        end else begin
          state_next = pha_pkg::S_PCHK_RD;
        end
      end
      pha_pkg::S_MAP: begin
        if (sts.page_last) state_next = pha_pkg::S_DONE;
      end
      pha_pkg::S_PCHK_RD: state_next = pha_pkg::S_PCHK_ACC;
      pha_pkg::S_PCHK_ACC: begin
        if (sts.sub_last && sts.page_last) begin
          state_next = pha_pkg::S_DONE;
        end else begin
          state_next = pha_pkg::S_PCHK_RD;
        end
      end
      pha_pkg::S_XLATE: begin
        state_next = (sts.command == pha_pkg::CMD_WRITE) ? pha_pkg::S_DONE : pha_pkg::S_DATA_RD;
      end
      pha_pkg::S_DATA_RD: state_next = pha_pkg::S_DONE;
      pha_pkg::S_DONE: begin
        if (out_free) state_next = pha_pkg::S_IDLE;
      end
      default: state_next = pha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_code = pha_pkg::ST_OK;
    req_stall    = (state != pha_pkg::S_IDLE);
    unique case (state)
      pha_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      pha_pkg::S_IDLE:  cmd.load_req = req_valid;
      pha_pkg::S_DECODE: begin
        unique case (sts.command)
          pha_pkg::CMD_ALLOC: begin
            cmd.res_set   = sts.size_zero;
            cmd.res_code  = pha_pkg::ST_BAD;
            cmd.scan_init = !sts.size_zero;
          end
          pha_pkg::CMD_FREE: begin
            cmd.res_set   = sts.free_bad;
            cmd.res_code  = pha_pkg::ST_BAD;
            cmd.mark_init = !sts.free_bad;
          end
          default: begin
            cmd.res_set  = sts.xlate_bad;
            cmd.res_code = pha_pkg::ST_BAD;
          end
        endcase
      end
      pha_pkg::S_SCAN_RD: ;
      pha_pkg::S_SCAN_CH: begin
        cmd.scan_chunk     = !sts.first_hit;
        cmd.scan_next_word = !sts.first_hit && sts.chunk_last && !sts.word_last;
      end
      pha_pkg::S_SCAN_END: cmd.scan_final = 1'b1;
      pha_pkg::S_ALLOC_CHK: begin
        cmd.res_set   = !sts.found;
        cmd.res_code  = pha_pkg::ST_NO_HOLE;
        cmd.span_init = sts.found;
      end
      pha_pkg::S_COUNT: cmd.count_step = 1'b1;
      pha_pkg::S_FRAME_CHK: begin
        cmd.res_set   = sts.frames_short;
        cmd.res_code  = pha_pkg::ST_NO_FRAME;
        cmd.mark_init = !sts.frames_short;
      end
      pha_pkg::S_MARK_RD: ;
      pha_pkg::S_MARK_WR: begin
        cmd.mark_write = 1'b1;
        cmd.word_next  = !sts.span_word_last;
        cmd.span_init  = sts.span_word_last && (sts.command == pha_pkg::CMD_ALLOC);
        cmd.pchk_init  = sts.span_word_last && (sts.command != pha_pkg::CMD_ALLOC);
      end
      pha_pkg::S_MAP: begin
        cmd.map_step = 1'b1;
        cmd.res_set  = sts.page_last;
      end
      pha_pkg::S_PCHK_RD: ;
      pha_pkg::S_PCHK_ACC: begin
        cmd.pchk_acc = 1'b1;
        cmd.res_set  = sts.sub_last && sts.page_last;
      end
      pha_pkg::S_XLATE: begin
        cmd.data_write = (sts.command == pha_pkg::CMD_WRITE);
        cmd.res_set    = (sts.command == pha_pkg::CMD_WRITE);
      end
      pha_pkg::S_DATA_RD: cmd.res_set = 1'b1;
      pha_pkg::S_DONE: cmd.load_out = out_free;
      default: ;
    endcase
  end

  `PHA_CHECK(a_no_overwrite, cmd.load_out |-> out_free, "response overwritten while pending")
  `PHA_CHECK(a_accept_decode, (req_valid && !req_stall) |=> (state == pha_pkg::S_DECODE), "accepted request not decoded")
  `PHA_CHECK_ALWAYS(a_reset_clear, $past(rst) |-> (state == pha_pkg::S_CLEAR), "reset did not start the clearing pass")

endmodule

FILE: design/pha_dp.sv
// ----------------------------------------------------------------------------
// pha_dp
// Allocator datapath: use bitmap, frame map, page table, data store and scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pha_dp #(
  parameter int LOGICAL_WORDS  = pha_pkg::LOGICAL_WORDS_DEF,
  parameter int PHYSICAL_WORDS = pha_pkg::PHYSICAL_WORDS_DEF,
  parameter int PAGE_WORDS     = pha_pkg::PAGE_WORDS_DEF,
  parameter int DATA_WIDTH     = pha_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pha_pkg::req_t           req,
  input  logic                    fit_policy_we,
  input  logic [pha_pkg::FIT_W-1:0] fit_policy_wdata,
  input  pha_pkg::ctl_cmd_t       cmd,
  output pha_pkg::ctl_sts_t       sts,
  output pha_pkg::rsp_t           rsp
);

  localparam int LA_W       = $clog2(LOGICAL_WORDS);
  localparam int PB         = $clog2(PAGE_WORDS);
  localparam int NUM_PAGES  = LOGICAL_WORDS / PAGE_WORDS;
  localparam int NUM_FRAMES = PHYSICAL_WORDS / PAGE_WORDS;
  localparam int PG_W       = $clog2(NUM_PAGES);
  localparam int FR_W       = $clog2(NUM_FRAMES);
  localparam int PA_W       = $clog2(PHYSICAL_WORDS);
  localparam int BM_W       = (PAGE_WORDS < 64) ? PAGE_WORDS : 64;
  localparam int BMB        = $clog2(BM_W);
  localparam int BM_D       = LOGICAL_WORDS / BM_W;
  localparam int WI_W       = $clog2(BM_D);
  localparam int CK_W       = BMB - 3;
  localparam int PWW        = PAGE_WORDS / BM_W;
  localparam int PS_SH      = $clog2(PWW);
  localparam int EW         = ((LA_W > pha_pkg::SIZE_W) ? LA_W : pha_pkg::SIZE_W) + 1;

  logic [pha_pkg::FIT_W-1:0]   fit_policy;
  pha_pkg::command_t           cmd_q;
  logic [EW-1:0]               addr_q;
  logic [EW-1:0]               size_q;
  logic [pha_pkg::VALUE_W-1:0] wval_q;

  logic [WI_W-1:0]             word_idx;
  logic [CK_W-1:0]             chunk;
  logic [LA_W-1:0]             run_start, best_start;
  logic [EW-1:0]               run_len, best_len;
  logic                        found;
  logic [PG_W-1:0]             pg;
  logic [PG_W:0]               needed;
  logic [FR_W:0]               free_count;
  logic [NUM_FRAMES-1:0]       frame_bits;
  logic [NUM_PAGES-1:0]        page_valid;
  logic                        empty;
  pha_pkg::rsp_t               res;

  logic [BM_W-1:0]             bm_rdata, bm_wdata, mask;
  logic                        bm_we;
  logic [FR_W-1:0]             pf_rdata, low_free;
  logic [PG_W-1:0]             pf_raddr, addr_page;
  logic                        pf_we;
  logic [DATA_WIDTH-1:0]       data_rdata, data_wdata;
  logic [PA_W-1:0]             data_addr;
  logic [DATA_WIDTH+pha_pkg::VALUE_W-1:0] wext;
  logic [pha_pkg::VALUE_W+DATA_WIDTH-1:0] rext;

  logic [EW-1:0]               base, span_end;
  logic [PG_W-1:0]             span_first, span_last;
  logic [WI_W-1:0]             first_w, last_w;
  logic [BMB-1:0]              lo, hi;
  logic                        addr_ge, is_first;
  logic [7:0]                  chunk_bits;
  logic [LA_W-1:0]             rs, bs, idx;
  logic [EW-1:0]               rl, bl;
  logic                        fd;

  assign addr_ge    = addr_q >= EW'(LOGICAL_WORDS);
  assign addr_page  = addr_q[LA_W-1:PB];
  assign base       = (cmd_q == pha_pkg::CMD_ALLOC) ? EW'(best_start) : addr_q;
  assign span_end   = base + size_q - EW'(1);
  assign span_first = base[LA_W-1:PB];
  assign span_last  = span_end[LA_W-1:PB];
  assign first_w    = base[LA_W-1:BMB];
  assign last_w     = span_end[LA_W-1:BMB];
  assign is_first   = (fit_policy != pha_pkg::FIT_BEST) && (fit_policy != pha_pkg::FIT_WORST);

  always_comb begin
    sts                = '0;
    sts.command        = cmd_q;
    sts.size_zero      = (size_q == '0);
    sts.free_bad       = sts.size_zero || addr_ge || (size_q > (EW'(LOGICAL_WORDS) - addr_q));
    sts.xlate_bad      = addr_ge || !page_valid[addr_page];
    sts.first_hit      = found && is_first;
    sts.found          = found;
    sts.chunk_last     = (chunk == '1);
    sts.word_last      = (word_idx == '1);
    sts.span_word_last = (word_idx == last_w);
    sts.page_last      = (pg == span_last);
    sts.sub_last       = ((word_idx & WI_W'(PWW - 1)) == WI_W'(PWW - 1));
    sts.frames_short   = 32'(needed) > 32'(free_count);
  end

  // Eight bitmap positions of the run search per cycle while a chunk is checked; an all-used chunk closes the last run.
  always_comb begin
    chunk_bits = cmd.scan_final ? 8'hFF : bm_rdata[{chunk, 3'b000} +: 8];
    rs = run_start;
    rl = run_len;
    bs = best_start;
    bl = best_len;
    fd = found;
    idx = '0;
    for (int j = 0; j < 8; j++) begin
      idx = {word_idx, chunk, 3'(j)};
      if (!chunk_bits[j]) begin
        if (rl == '0) rs = idx;
        rl = rl + EW'(1);
      end else begin
        if (rl >= size_q) begin
          if (fit_policy == pha_pkg::FIT_BEST) begin
            if (!fd || rl < bl) begin
              fd = 1'b1;
              bs = rs;
              bl = rl;
            end
          end else if (fit_policy == pha_pkg::FIT_WORST) begin
            if (!fd || rl > bl) begin
              fd = 1'b1;
              bs = rs;
              bl = rl;
            end
          end else if (!fd) begin
            fd = 1'b1;
            bs = rs;
          end
        end
        rl = '0;
      end
    end
  end

  always_comb begin
    lo = (word_idx == first_w) ? base[BMB-1:0] : '0;
    hi = (word_idx == last_w) ? span_end[BMB-1:0] : '1;
    for (int i = 0; i < BM_W; i++) begin
      mask[i] = (BMB'(i) >= lo) && (BMB'(i) <= hi);
    end
  end

  always_comb begin
    low_free = '0;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (!frame_bits[f]) low_free = FR_W'(f);
    end
  end

  assign bm_we    = cmd.clear_step || cmd.mark_write;
  assign bm_wdata = cmd.clear_step ? '0 :
                    (cmd_q == pha_pkg::CMD_ALLOC) ? (bm_rdata | mask) : (bm_rdata & ~mask);
  assign pf_we    = cmd.map_step && !page_valid[pg];
  assign pf_raddr = (cmd_q == pha_pkg::CMD_FREE) ? pg : addr_page;
  assign data_addr = {pf_rdata, addr_q[PB-1:0]};
  assign wext       = {{DATA_WIDTH{1'b0}}, wval_q};
  assign data_wdata = wext[DATA_WIDTH-1:0];
  assign rext       = {{pha_pkg::VALUE_W{1'b0}}, data_rdata};

  pha_ram #(.WIDTH(BM_W), .DEPTH(BM_D)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (word_idx),
    .wdata (bm_wdata),
    .raddr (word_idx),
    .rdata (bm_rdata)
  );

  pha_ram #(.WIDTH(FR_W), .DEPTH(NUM_PAGES)) u_page_table (
    .clk   (clk),
    .we    (pf_we),
    .waddr (pg),
    .wdata (low_free),
    .raddr (pf_raddr),
    .rdata (pf_rdata)
  );

  pha_ram #(.WIDTH(DATA_WIDTH), .DEPTH(PHYSICAL_WORDS)) u_data (
    .clk   (clk),
    .we    (cmd.data_write),
    .waddr (data_addr),
    .wdata (data_wdata),
    .raddr (data_addr),
    .rdata (data_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= '0;
      word_idx   <= '0;
      free_count <= (FR_W + 1)'(NUM_FRAMES);
      frame_bits <= '0;
      page_valid <= '0;
    end else begin
      if (fit_policy_we) fit_policy <= fit_policy_wdata;

      if (cmd.scan_init) begin
        word_idx <= '0;
      end else if (cmd.mark_init) begin
        word_idx <= first_w;
      end else if (cmd.pchk_init) begin
        word_idx <= WI_W'(span_first) << PS_SH;
      end else if (cmd.clear_step || cmd.scan_next_word || cmd.word_next || cmd.pchk_acc) begin
        word_idx <= word_idx + WI_W'(1);
      end

      if (pf_we) begin
        frame_bits[low_free] <= 1'b1;
        page_valid[pg]       <= 1'b1;
        free_count           <= free_count - (FR_W + 1)'(1);
      end
      if (cmd.pchk_acc && sts.sub_last && empty && (bm_rdata == '0) && page_valid[pg]) begin
        frame_bits[pf_rdata] <= 1'b0;
        page_valid[pg]       <= 1'b0;
        free_count           <= free_count + (FR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cmd_q  <= req.command;
      addr_q <= EW'(req.req_address);
      size_q <= EW'(req.alloc_size);
      wval_q <= req.write_value;
    end

    if (cmd.scan_init) begin
      chunk   <= '0;
      run_len <= '0;
      found   <= 1'b0;
    end else if (cmd.scan_chunk || cmd.scan_final) begin
      chunk      <= chunk + CK_W'(1);
      run_start  <= rs;
      run_len    <= rl;
      best_start <= bs;
      best_len   <= bl;
      found      <= fd;
    end

    if (cmd.span_init || cmd.pchk_init) begin
      pg     <= span_first;
      needed <= '0;
      empty  <= 1'b1;
    end else if (cmd.count_step || cmd.map_step) begin
      pg <= pg + PG_W'(1);
      if (cmd.count_step && !page_valid[pg]) needed <= needed + (PG_W + 1)'(1);
    end else if (cmd.pchk_acc) begin
      if (sts.sub_last) begin
        pg    <= pg + PG_W'(1);
        empty <= 1'b1;
      end else begin
        empty <= empty && (bm_rdata == '0);
      end
    end

    if (cmd.res_set) begin
      res.status         <= cmd.res_code;
      res.result_address <= ((cmd.res_code == pha_pkg::ST_OK) && (cmd_q == pha_pkg::CMD_ALLOC)) ?
                            pha_pkg::ADDR_W'(best_start) : '0;
      res.read_data      <= ((cmd.res_code == pha_pkg::ST_OK) && (cmd_q == pha_pkg::CMD_READ)) ?
                            rext[pha_pkg::VALUE_W-1:0] : '0;
    end

    if (cmd.load_out) rsp <= res;
  end

  `PHA_CHECK(a_frame_count, 32'(free_count) == (NUM_FRAMES - $countones(frame_bits)), "free frame count out of step with frame map")
  `PHA_CHECK(a_map_has_frame, pf_we |-> !(&frame_bits), "page mapped with no free frame")

endmodule

FILE: design/paged_heap_allocator_unit.sv
// A read or write translates its address and accesses the data store; a free
// marks each bitmap word of the range and then checks each bitmap word of every
// touched page; an allocate scans the bitmap, then counts, marks and maps pages.
// One request at a time; the allocation scan over the use bitmap RAM sets the rate.
// Synchronous reset; afterwards a clearing pass of one bitmap word per cycle
// (1024 bitmap words by default) runs before the first request is taken.
// ----------------------------------------------------------------------------
// paged_heap_allocator_unit
// Word-granular heap allocator with paged translation onto a physical store.
// ----------------------------------------------------------------------------
module paged_heap_allocator_unit #(
  parameter int LOGICAL_WORDS  = pha_pkg::LOGICAL_WORDS_DEF,
  parameter int PHYSICAL_WORDS = pha_pkg::PHYSICAL_WORDS_DEF,
  parameter int PAGE_WORDS     = pha_pkg::PAGE_WORDS_DEF,
  parameter int DATA_WIDTH     = pha_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  pha_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output pha_pkg::rsp_t             rsp,
  input  logic                      fit_policy_we,
  input  logic [pha_pkg::FIT_W-1:0] fit_policy_wdata
);

  pha_pkg::ctl_cmd_t cmd;
  pha_pkg::ctl_sts_t sts;

  pha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pha_dp #(
    .LOGICAL_WORDS  (LOGICAL_WORDS),
    .PHYSICAL_WORDS (PHYSICAL_WORDS),
    .PAGE_WORDS     (PAGE_WORDS),
    .DATA_WIDTH     (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .req              (req),
    .fit_policy_we    (fit_policy_we),
    .fit_policy_wdata (fit_policy_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .rsp              (rsp)
  );

endmodule
